[rtl/cl_pkg.sv]
package cl_pkg;

  // Command codes on the request channel
  localparam logic [2:0] CMD_SET_NAV    = 3'd0;
  localparam logic [2:0] CMD_SEND       = 3'd1;
  localparam logic [2:0] CMD_START_FEED = 3'd2;
  localparam logic [2:0] CMD_CLEAR      = 3'd3;
  localparam logic [2:0] CMD_TICK       = 3'd4;
  localparam logic [2:0] CMD_ACK        = 3'd5;

  // Feed status codes as reported on the result channel
  localparam logic [2:0] STAT_IDLE    = 3'd0;
  localparam logic [2:0] STAT_PENDING = 3'd1;
  localparam logic [2:0] STAT_DONE    = 3'd2;
  localparam logic [2:0] STAT_BUSY    = 3'd3;
  localparam logic [2:0] STAT_FAILED  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_ACK_TIMEOUT    = 3'd0;
  localparam logic [2:0] REG_MAX_RETRIES    = 3'd1;
  localparam logic [2:0] REG_SPRAYER_MAX    = 3'd2;
  localparam logic [2:0] REG_CODE_OK        = 3'd3;
  localparam logic [2:0] REG_CODE_DUPLICATE = 3'd4;
  localparam logic [2:0] REG_CODE_BUSY      = 3'd5;

  localparam logic [15:0] ACK_TIMEOUT_RST    = 16'd1000;
  localparam logic [7:0]  MAX_RETRIES_RST    = 8'd3;
  localparam logic [7:0]  SPRAYER_MAX_RST    = 8'd3;
  localparam logic [7:0]  CODE_OK_RST        = 8'd0;
  localparam logic [7:0]  CODE_DUPLICATE_RST = 8'd1;
  localparam logic [7:0]  CODE_BUSY_RST      = 8'd2;

  localparam logic [7:0] GRAMS_LIMIT = 8'd100;

  typedef struct packed {
    logic [15:0] ack_timeout_ticks;
    logic [7:0]  max_retries;
    logic [7:0]  sprayer_max;
    logic [7:0]  code_ok;
    logic [7:0]  code_duplicate;
    logic [7:0]  code_busy;
  } cfg_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_PENDING = 5'b00010,
    PH_DONE    = 5'b00100,
    PH_BUSY    = 5'b01000,
    PH_FAILED  = 5'b10000
  } feed_phase_t;

  // What the feed controller reports for the request in hand
  typedef struct packed {
    logic        tx;
    logic [15:0] seq;
    logic        accepted;
    logic [2:0]  status;
    logic [7:0]  ack_code;
  } feed_res_t;

  function automatic logic [2:0] phase_code(feed_phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:    code = STAT_IDLE;
      PH_PENDING: code = STAT_PENDING;
      PH_DONE:    code = STAT_DONE;
      PH_BUSY:    code = STAT_BUSY;
      PH_FAILED:  code = STAT_FAILED;
      default:    code = STAT_IDLE;
    endcase
    return code;
  endfunction

endpackage

[rtl/cl_req_if.sv]
interface cl_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  nav_code;
  logic [7:0]  grams_req;
  logic [7:0]  sprayer_req;
  logic [15:0] ack_seq;
  logic [7:0]  ack_code;

  modport source (output valid, cmd, nav_code, grams_req, sprayer_req, ack_seq, ack_code,
                  input ready);
  modport sink (input valid, cmd, nav_code, grams_req, sprayer_req, ack_seq, ack_code,
                output ready);
endinterface

[rtl/cl_rsp_if.sv]
interface cl_rsp_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [15:0] tx_seq;
  logic        tx_feed;
  logic [7:0]  tx_nav;
  logic [6:0]  tx_grams;
  logic [7:0]  tx_sprayer;
  logic [2:0]  feed_status;
  logic [7:0]  last_ack_code;
  logic        accepted;

  modport source (output valid, tx_valid, tx_seq, tx_feed, tx_nav, tx_grams, tx_sprayer,
                  feed_status, last_ack_code, accepted,
                  input ready);
  modport sink (input valid, tx_valid, tx_seq, tx_feed, tx_nav, tx_grams, tx_sprayer,
                feed_status, last_ack_code, accepted,
                output ready);
endinterface

[rtl/command_link_with_ack_retry.sv]
// Command link sender with an acknowledged, retried feed action.
//
// req carries one event per request (set nav, send, start feed, clear,
// tick, ack); rsp returns exactly one result per request, giving the packet
// to transmit (if any), the current navigation values and the feed status.
// wr_en/wr_index/wr_data write the six configuration registers; write only
// while no request is outstanding.
//
// A request's result is captured in the result register when the request is
// accepted and is offered on rsp from then on, until rsp takes it.
// Throughput: one request per cycle while rsp is not stalled; the whole update is a single stage
// of compares and increments ahead of the result register.
// req.ready is high while the result register is empty or being drained,
// so a stalled receiver holds one result and then back-pressures req.
//
// Reset clears the sequence counter, navigation values and feed state to
// idle and loads the configuration registers with their defaults.
module command_link_with_ack_retry
  import cl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cl_req_if.sink      req,
  cl_rsp_if.source    rsp,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);

  cfg_t        cfg;
  logic [15:0] next_seq;
  logic [7:0]  nav_now;
  logic [6:0]  grams_now;
  logic [7:0]  sprayer_now;
  logic [7:0]  nav_next;
  logic [6:0]  grams_next;
  logic [7:0]  sprayer_next;
  logic        fire;
  logic        is_send;
  logic        bump_seq;
  feed_res_t   fres;

  logic        out_valid;
  logic        tx_valid_next;
  logic [15:0] tx_seq_next;
  logic        tx_feed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_timeout_ticks <= ACK_TIMEOUT_RST;
      cfg.max_retries       <= MAX_RETRIES_RST;
      cfg.sprayer_max       <= SPRAYER_MAX_RST;
      cfg.code_ok           <= CODE_OK_RST;
      cfg.code_duplicate    <= CODE_DUPLICATE_RST;
      cfg.code_busy         <= CODE_BUSY_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ACK_TIMEOUT:    cfg.ack_timeout_ticks <= wr_data;
        REG_MAX_RETRIES:    cfg.max_retries       <= wr_data[7:0];
        REG_SPRAYER_MAX:    cfg.sprayer_max       <= wr_data[7:0];
        REG_CODE_OK:        cfg.code_ok           <= wr_data[7:0];
        REG_CODE_DUPLICATE: cfg.code_duplicate    <= wr_data[7:0];
        REG_CODE_BUSY:      cfg.code_busy         <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign req.ready = !out_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  cl_feed u_feed (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cmd      (req.cmd),
    .ack_seq  (req.ack_seq),
    .ack_code (req.ack_code),
    .next_seq (next_seq),
    .cfg      (cfg),
    .res      (fres)
  );

  assign is_send  = (req.cmd == CMD_SEND);
  // a refused start feed does not consume a sequence number
  assign bump_seq = is_send || ((req.cmd == CMD_START_FEED) && fres.accepted);

  always_comb begin
    nav_next     = nav_now;
    grams_next   = grams_now;
    sprayer_next = sprayer_now;
    if (req.cmd == CMD_SET_NAV) begin
      nav_next     = req.nav_code;
      grams_next   = (req.grams_req > GRAMS_LIMIT) ? GRAMS_LIMIT[6:0] : req.grams_req[6:0];
      sprayer_next = (req.sprayer_req > cfg.sprayer_max) ? cfg.sprayer_max : req.sprayer_req;
    end
  end

  always_comb begin
    tx_valid_next = is_send || fres.tx;
    tx_feed_next  = fres.tx;
    if (is_send) begin
      tx_seq_next = next_seq;
    end else if (fres.tx) begin
      tx_seq_next = fres.seq;
    end else begin
      tx_seq_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq    <= 16'd0;
      nav_now     <= 8'd0;
      grams_now   <= 7'd0;
      sprayer_now <= 8'd0;
    end else if (fire) begin
      if (bump_seq) begin
        next_seq <= next_seq + 16'd1;
      end
      nav_now     <= nav_next;
      grams_now   <= grams_next;
      sprayer_now <= sprayer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.tx_valid      <= tx_valid_next;
      rsp.tx_seq        <= tx_seq_next;
      rsp.tx_feed       <= tx_feed_next;
      rsp.tx_nav        <= nav_next;
      rsp.tx_grams      <= grams_next;
      rsp.tx_sprayer    <= sprayer_next;
      rsp.feed_status   <= fres.status;
      rsp.last_ack_code <= fres.ack_code;
      rsp.accepted      <= fres.accepted;
    end
  end

  assign rsp.valid = out_valid;

endmodule

[rtl/cl_feed.sv]
module cl_feed
  import cl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [2:0]  cmd,
  input  logic [15:0] ack_seq,
  input  logic [7:0]  ack_code,
  input  logic [15:0] next_seq,
  input  cfg_t        cfg,
  output feed_res_t   res
);

  feed_phase_t phase, phase_next;
  logic [15:0] held_seq, held_seq_next;
  logic [15:0] ticks, ticks_next;
  logic [7:0]  sends, sends_next;
  logic [7:0]  ack_held, ack_held_next;

  logic        pending;
  logic [15:0] ticks_inc;
  logic        expire;
  logic        exhausted;
  logic        tx;
  logic        acc;

  assign pending   = (phase == PH_PENDING);
  assign ticks_inc = (ticks == 16'hFFFF) ? ticks : ticks + 16'd1;
  // compare is against the already advanced count
  assign expire    = (ticks_inc >= cfg.ack_timeout_ticks);
  assign exhausted = (sends > cfg.max_retries) || (sends == 8'hFF);

  always_comb begin
    phase_next    = phase;
    held_seq_next = held_seq;
    ticks_next    = ticks;
    sends_next    = sends;
    ack_held_next = ack_held;
    tx            = 1'b0;
    acc           = 1'b1;
    case (cmd)
      CMD_START_FEED: begin
        if (pending) begin
          acc = 1'b0;
        end else begin
          phase_next    = PH_PENDING;
          held_seq_next = next_seq;
          sends_next    = 8'd1;
          ticks_next    = 16'd0;
          tx            = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (!pending) begin
          phase_next = PH_IDLE;
        end
      end
      CMD_TICK: begin
        if (pending) begin
          ticks_next = ticks_inc;
          if (expire) begin
            if (exhausted) begin
              phase_next = PH_FAILED;
            end else begin
              sends_next = sends + 8'd1;
              ticks_next = 16'd0;
              tx         = 1'b1;
            end
          end
        end
      end
      CMD_ACK: begin
        if (pending && (ack_seq == held_seq)) begin
          ack_held_next = ack_code;
          if ((ack_code == cfg.code_ok) || (ack_code == cfg.code_duplicate)) begin
            phase_next = PH_DONE;
          end else if (ack_code == cfg.code_busy) begin
            phase_next = PH_BUSY;
          end else begin
            phase_next = PH_FAILED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      held_seq <= 16'd0;
      ticks    <= 16'd0;
      sends    <= 8'd0;
      ack_held <= CODE_OK_RST;
    end else if (fire) begin
      phase    <= phase_next;
      held_seq <= held_seq_next;
      ticks    <= ticks_next;
      sends    <= sends_next;
      ack_held <= ack_held_next;
    end
  end

  assign res.tx       = tx;
  assign res.seq      = held_seq_next;
  assign res.accepted = acc;
  assign res.status   = phase_code(phase_next);
  assign res.ack_code = ack_held_next;

endmodule

[rtl/cl_checker.sv]
module cl_checker
  import cl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        tx_valid,
  input logic [15:0] tx_seq,
  input logic        tx_feed,
  input logic [2:0]  feed_status,
  input logic        accepted
);

  // a result stays put until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_seq) && $stable(feed_status))
    else $error("result changed while stalled");

  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no result after an accepted request");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid straight after reset");

  a_no_tx_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !tx_valid |-> (tx_seq == 16'd0) && !tx_feed)
    else $error("packet fields set without a transmission");

  a_refused: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !accepted |-> !tx_valid && (feed_status == STAT_PENDING))
    else $error("refused start feed while not pending");

endmodule

bind command_link_with_ack_retry cl_checker u_cl_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .tx_valid    (rsp.tx_valid),
  .tx_seq      (rsp.tx_seq),
  .tx_feed     (rsp.tx_feed),
  .feed_status (rsp.feed_status),
  .accepted    (rsp.accepted)
);
